// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define LLT_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("llt assertion failed");

// antecedent implies consequent in the same cycle
`define LLT_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("llt assertion failed");

// antecedent implies consequent in the next cycle
`define LLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("llt assertion failed");

`endif

// ----- rtl/llt_pkg.sv -----
// Shared types and constants for the least-loaded till scheduler
`default_nettype none
package llt_pkg;

  localparam int LOAD_W = 32;
  localparam int DUR_W  = 16;
  localparam int CFG_W  = 4;

  localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

  // per-cycle command broadcast to every till cell
  typedef struct packed {
    logic insert;   // head till takes the request and is re-inserted
    logic clear;    // end of list: all loads back to zero
    logic reorder;  // odd-even transposition pass
    logic phase;    // which neighbour pairs compare in this pass
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/llt_channels.sv -----
// Valid/ready channel interfaces for requests, results and configuration
`default_nettype none
interface llt_in_if;
  logic                       valid;
  logic                       ready;
  logic [llt_pkg::DUR_W-1:0]  duration;
  logic                       last_customer;

  modport source (output valid, output duration, output last_customer, input ready);
  modport sink   (input valid, input duration, input last_customer, output ready);
endinterface

interface llt_out_if;
  logic                       valid;
  logic                       ready;
  logic [llt_pkg::LOAD_W-1:0] makespan;

  modport source (output valid, output makespan, input ready);
  modport sink   (input valid, input makespan, output ready);
endinterface

interface llt_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [llt_pkg::CFG_W-1:0]  tills_in_use;

  modport source (output valid, output tills_in_use, input ready);
  modport sink   (input valid, input tills_in_use, output ready);
endinterface
`default_nettype wire

// ----- rtl/llt_cell.sv -----
// One till cell of the sorted load chain
`default_nettype none
module llt_cell #(
  parameter int MAX_TILLS = 8,
  parameter int POS       = 0,
  parameter int IW        = 3,
  parameter int NW        = 4,
  parameter int KW        = 1 + 32 + 3
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  llt_pkg::cell_ctl_t  ctl,
  input  wire  [NW-1:0]       n_eff,
  input  wire  [KW-1:0]       ins_key,
  input  wire  [KW-1:0]       left_key,
  input  wire  [KW-1:0]       right_key,
  output logic [KW-1:0]       own_key
);
  import llt_pkg::*;

  logic [LOAD_W-1:0] load_r, load_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic              inactive;
  logic              lo_side;

  // key order: active tills first, then load, then till index
  assign inactive = 32'(idx_r) >= 32'(n_eff);
  assign own_key  = {inactive, load_r, idx_r};
  assign lo_side  = (POS % 2) == int'(ctl.phase);

  always_comb begin
    load_nxt = load_r;
    idx_nxt  = idx_r;
    if (ctl.clear) begin
      load_nxt = '0;
      idx_nxt  = IW'(POS);
    end else if (ctl.insert) begin
      if (POS < MAX_TILLS - 1 && right_key < ins_key) begin
        load_nxt = right_key[KW-2:IW];
        idx_nxt  = right_key[IW-1:0];
      end else if (POS == 0 || own_key < ins_key) begin
        load_nxt = ins_key[KW-2:IW];
        idx_nxt  = ins_key[IW-1:0];
      end
    end else if (ctl.reorder) begin
      if (lo_side) begin
        if (POS < MAX_TILLS - 1 && right_key < own_key) begin
          load_nxt = right_key[KW-2:IW];
          idx_nxt  = right_key[IW-1:0];
        end
      end else if (POS > 0 && own_key < left_key) begin
        load_nxt = left_key[KW-2:IW];
        idx_nxt  = left_key[IW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= '0;
      idx_r  <= IW'(POS);
    end else begin
      load_r <= load_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/least_loaded_till_makespan.sv -----
// Least-loaded till scheduler: top level with the cell chain and result register
// Throughput: one job request per cycle; in_req.ready is low while a result waits unaccepted or a reorder runs.
// Latency: makespan is valid on the cycle after the last job of a list is accepted.
// A tills_in_use write starts an odd-even transposition reorder in the cell chain;
// in_req.ready is low during it.
// Reset: all loads zero, tills_in_use = 1, no result pending.
`default_nettype none
module least_loaded_till_makespan #(
  parameter int MAX_TILLS = 8
) (
  input  wire        clk,
  input  wire        rst_n,
  llt_in_if.sink     in_req,
  llt_out_if.source  out_res,
  llt_cfg_if.sink    cfg_wr
);
  import llt_pkg::*;
  `include "assert_macros.svh"

  localparam int IW = (MAX_TILLS > 1) ? $clog2(MAX_TILLS) : 1;
  localparam int NW = $clog2(MAX_TILLS + 1);
  localparam int KW = 1 + LOAD_W + IW;

  logic [CFG_W-1:0]  tills_r;
  logic [NW-1:0]     n_eff;
  logic [NW-1:0]     sort_cnt_r;
  logic              sorting;
  logic [LOAD_W-1:0] span_r;
  logic [LOAD_W-1:0] total_r;
  logic              out_valid_r;
  logic [KW-1:0]     keys [MAX_TILLS];
  logic [KW-1:0]     head_key;
  logic [KW-1:0]     ins_key;
  logic [LOAD_W:0]   sum;
  logic [LOAD_W-1:0] new_load;
  logic [LOAD_W-1:0] span_cand;
  logic              in_acc;
  logic              cfg_acc;
  cell_ctl_t         ctl;

  always_comb begin
    if (tills_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(tills_r) > MAX_TILLS) begin
      n_eff = NW'(MAX_TILLS);
    end else begin
      n_eff = NW'(tills_r);
    end
  end

  assign sorting  = sort_cnt_r != '0;
  assign head_key = keys[0];

  // head of the chain is the least-loaded active till
  assign sum       = {1'b0, head_key[KW-2:IW]} + (LOAD_W + 1)'(in_req.duration);
  assign new_load  = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
  assign ins_key   = {1'b0, new_load, head_key[IW-1:0]};
  assign span_cand = (new_load > span_r) ? new_load : span_r;

  assign in_req.ready = !sorting && (!out_valid_r || out_res.ready);
  assign in_acc       = in_req.valid && in_req.ready;
  assign cfg_wr.ready = 1'b1;
  assign cfg_acc      = cfg_wr.valid;

  assign ctl.insert  = in_acc;
  assign ctl.clear   = in_acc && in_req.last_customer;
  assign ctl.reorder = sorting;
  assign ctl.phase   = sort_cnt_r[0];

  for (genvar g = 0; g < MAX_TILLS; g++) begin : g_cell
    logic [KW-1:0] lk;
    logic [KW-1:0] rk;
    if (g > 0) begin : g_l
      assign lk = keys[g-1];
    end else begin : g_l0
      assign lk = '0;
    end
    if (g < MAX_TILLS - 1) begin : g_r
      assign rk = keys[g+1];
    end else begin : g_rn
      assign rk = '1;
    end
    llt_cell #(
      .MAX_TILLS (MAX_TILLS),
      .POS       (g),
      .IW        (IW),
      .NW        (NW),
      .KW        (KW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .n_eff     (n_eff),
      .ins_key   (ins_key),
      .left_key  (lk),
      .right_key (rk),
      .own_key   (keys[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tills_r     <= CFG_W'(1);
      sort_cnt_r  <= '0;
      span_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_acc) begin
        tills_r    <= cfg_wr.tills_in_use;
        sort_cnt_r <= NW'(MAX_TILLS);
      end else if (sorting) begin
        sort_cnt_r <= sort_cnt_r - NW'(1);
      end
      if (in_acc) begin
        span_r <= in_req.last_customer ? '0 : span_cand;
      end
      if (in_acc && in_req.last_customer) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_req.last_customer) begin
      total_r <= span_cand;
    end
  end

  assign out_res.valid    = out_valid_r;
  assign out_res.makespan = total_r;

  `LLT_ASSERT_IMPLY(a_head_active, !sorting, !head_key[KW-1])
  `LLT_ASSERT_ALWAYS(a_span_covers_head, span_r >= head_key[KW-2:IW])
  `LLT_ASSERT_NEXT(a_last_gives_result, in_acc && in_req.last_customer, out_valid_r)
  `LLT_ASSERT_NEXT(a_cfg_starts_reorder, cfg_acc, sorting)

endmodule
`default_nettype wire
